// ===== hw/rtl/tcw_pkg.sv =====
// Shared types, constants and helpers of the text console writer.
package tcw_pkg;

  // Screen geometry
  localparam int unsigned COLUMNS      = 80;
  localparam int unsigned ROWS         = 25;
  localparam int unsigned TOTAL_CELLS  = COLUMNS * ROWS;
  localparam int unsigned SCROLL_CELLS = TOTAL_CELLS - COLUMNS;

  // Field widths
  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned ADDR_W = 11;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned CELL_W = 16;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [CELL_W-1:0] cell_t;

  localparam char_t ATTR_RESET = 8'h07;

  // Modes
  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Control characters
  localparam char_t CH_BS    = 8'd8;
  localparam char_t CH_TAB   = 8'd9;
  localparam char_t CH_NL    = 8'd10;
  localparam char_t CH_CR    = 8'd13;
  localparam char_t CH_SPACE = 8'd32;
  localparam char_t CH_GRAVE = 8'd96;

  typedef struct packed {
    logic [1:0] mode;
    char_t      char_code;
    addr_t      read_address;
  } in_item_t;

  typedef struct packed {
    col_t  cursor_col;
    row_t  cursor_row;
    char_t read_char;
    char_t read_attr;
    logic  scrolled;
  } out_item_t;

  // Screen memory port
  typedef struct packed {
    logic  we;
    addr_t waddr;
    cell_t wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

  function automatic addr_t cell_addr(row_t row, col_t col);
    return addr_t'(row) * addr_t'(COLUMNS) + addr_t'(col);
  endfunction

  // Shift maps letters above the grave accent down by 32, the rest by 16
  function automatic char_t map_char(char_t ch, logic shift);
    char_t res;
    res = ch;
    if (shift) begin
      res = (ch > CH_GRAVE) ? ch - 8'd32 : ch - 8'd16;
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/tcw_screen.sv =====
// Screen cell memory: one write port, one read port with registered data.
module tcw_screen (
  input  logic              clk_i,
  input  tcw_pkg::mem_req_t req_i,
  output tcw_pkg::cell_t    rdata_o
);

  tcw_pkg::cell_t mem [tcw_pkg::TOTAL_CELLS];
  tcw_pkg::cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/text_console_writer.sv =====
// Top level of the text console writer: control sequencer around the screen memory.
//
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  input    | in_valid_i, in_ready_o, in_data_i    | in
//  result   | out_valid_o, out_ready_i, out_data_o | out
//  config   | cfg_we_i, cfg_wdata_i (attribute)    | in
//
// Sequence: a plain put is accepted, then does its one memory write; a mode with no
// memory work is accepted, then finishes; a read passes the registered read port;
// a tab writes four cells, one cell per cycle. A scroll copies or blanks one cell per
// cycle; a clear is accepted, dispatched, then writes one cell per cycle. The single
// memory write port sets this.
// Reset clears cursor, floor and shift and sets the attribute to 0x07; the screen
// holds garbage until written. One beat is in flight at a time; a finished result
// sits in the output register while the next input beat is taken, and a stalled
// output only blocks when a second result is ready.
module text_console_writer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tcw_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tcw_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  tcw_pkg::char_t     cfg_wdata_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SCROLL = 3'd2;
  localparam logic [2:0] S_CLEAR  = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  localparam tcw_pkg::addr_t LAST_CELL  = tcw_pkg::addr_t'(tcw_pkg::TOTAL_CELLS - 1);
  localparam tcw_pkg::addr_t END_SCROLL = tcw_pkg::addr_t'(tcw_pkg::TOTAL_CELLS);
  localparam tcw_pkg::addr_t COPY_LEN   = tcw_pkg::addr_t'(tcw_pkg::SCROLL_CELLS);
  localparam tcw_pkg::addr_t ROW_LEN    = tcw_pkg::addr_t'(tcw_pkg::COLUMNS);
  localparam tcw_pkg::col_t  LAST_COL   = tcw_pkg::col_t'(tcw_pkg::COLUMNS - 1);
  localparam tcw_pkg::row_t  PAST_ROW   = tcw_pkg::row_t'(tcw_pkg::ROWS);
  localparam tcw_pkg::row_t  LAST_ROW   = tcw_pkg::row_t'(tcw_pkg::ROWS - 1);

  logic [2:0]         state_q, state_d;
  tcw_pkg::in_item_t  item_q, item_d;
  tcw_pkg::char_t     attr_q;
  tcw_pkg::row_t      row_q, row_d, frow_q, frow_d;
  tcw_pkg::col_t      col_q, col_d, fcol_q, fcol_d;
  logic               shift_q, shift_d;
  logic [1:0]         tab_q, tab_d;
  logic               scr_q, scr_d;
  tcw_pkg::addr_t     cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  tcw_pkg::out_item_t out_q, out_d;

  tcw_pkg::mem_req_t  mem_req;
  tcw_pkg::cell_t     rdata;
  tcw_pkg::cell_t     blank;
  tcw_pkg::addr_t     cur_addr;
  logic               in_range;
  logic               above_floor;
  logic               done;
  logic               accept;

  tcw_screen u_screen (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  assign blank       = {attr_q, tcw_pkg::CH_SPACE};
  assign cur_addr    = tcw_pkg::cell_addr(row_q, col_q);
  assign in_range    = item_q.read_address < END_SCROLL;
  assign above_floor = (row_q > frow_q) || ((row_q == frow_q) && (col_q > fcol_q));
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    row_d   = row_q;
    col_d   = col_q;
    frow_d  = frow_q;
    fcol_d  = fcol_q;
    shift_d = shift_q;
    tab_d   = tab_q;
    scr_d   = scr_q;
    cnt_d   = cnt_q;
    mem_req = '0;
    done    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_d  = in_data_i;
          tab_d   = '0;
          scr_d   = 1'b0;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        case (item_q.mode)
          tcw_pkg::MODE_PUT: begin
            if (row_q == PAST_ROW) begin
              // cursor ran off the bottom: scroll before touching the byte
              state_d = S_SCROLL;
              cnt_d   = '0;
            end else if (item_q.char_code == tcw_pkg::CH_TAB) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = cur_addr;
              mem_req.wdata = {attr_q, tcw_pkg::map_char(tcw_pkg::CH_SPACE, shift_q)};
              if (col_q == LAST_COL) begin
                col_d = '0;
                row_d = row_q + 1'b1;
              end else begin
                col_d = col_q + 1'b1;
              end
              tab_d = tab_q + 1'b1;
              done  = (tab_q == 2'd3);
            end else begin
              done = 1'b1;
              case (item_q.char_code)
                tcw_pkg::CH_NL: begin
                  shift_d = 1'b0;
                  row_d   = row_q + 1'b1;
                  col_d   = '0;
                  frow_d  = row_q + 1'b1;
                  fcol_d  = '0;
                end
                tcw_pkg::CH_CR: begin
                  shift_d = ~shift_q;
                end
                tcw_pkg::CH_BS: begin
                  if (above_floor) begin
                    if (col_q == '0) begin
                      col_d = LAST_COL;
                      row_d = row_q - 1'b1;
                    end else begin
                      col_d = col_q - 1'b1;
                    end
                    mem_req.we    = 1'b1;
                    mem_req.waddr = cur_addr - 1'b1;
                    mem_req.wdata = blank;
                  end
                end
                default: begin
                  if (item_q.char_code >= tcw_pkg::CH_SPACE) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = cur_addr;
                    mem_req.wdata = {attr_q, tcw_pkg::map_char(item_q.char_code, shift_q)};
                    if (col_q == LAST_COL) begin
                      col_d = '0;
                      row_d = row_q + 1'b1;
                    end else begin
                      col_d = col_q + 1'b1;
                    end
                  end
                end
              endcase
            end
          end
          tcw_pkg::MODE_READ: begin
            mem_req.re    = in_range;
            mem_req.raddr = item_q.read_address;
            state_d       = S_RESP;
          end
          tcw_pkg::MODE_CLEAR: begin
            state_d = S_CLEAR;
            cnt_d   = '0;
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end

      S_SCROLL: begin
        // read runs one row ahead of the write, so the copy never overlaps
        mem_req.re    = cnt_q < COPY_LEN;
        mem_req.raddr = cnt_q + ROW_LEN;
        mem_req.we    = (cnt_q != '0);
        mem_req.waddr = cnt_q - 1'b1;
        mem_req.wdata = (cnt_q <= COPY_LEN) ? rdata : blank;
        if (cnt_q == END_SCROLL) begin
          row_d   = LAST_ROW;
          col_d   = '0;
          scr_d   = 1'b1;
          state_d = S_EXEC;
          if (frow_q != '0) begin
            frow_d = frow_q - 1'b1;
          end else begin
            fcol_d = '0;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt_q;
        mem_req.wdata = blank;
        if (cnt_q == LAST_CELL) begin
          row_d  = '0;
          col_d  = '0;
          frow_d = '0;
          fcol_d = '0;
          done   = 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_RESP: begin
        done = 1'b1;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // result beat: load the output register, or park in S_RESP if it is full
    out_valid_d          = out_valid_q && !out_ready_i;
    out_d                = out_q;
    out_d.cursor_col     = col_d;
    out_d.cursor_row     = row_d;
    out_d.scrolled       = scr_d;
    if ((item_q.mode == tcw_pkg::MODE_READ) && in_range) begin
      out_d.read_char = rdata[7:0];
      out_d.read_attr = rdata[15:8];
    end else begin
      out_d.read_char = '0;
      out_d.read_attr = '0;
    end
    if (done) begin
      if (!out_valid_d) begin
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end else begin
        state_d = S_RESP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      attr_q      <= tcw_pkg::ATTR_RESET;
      row_q       <= '0;
      col_q       <= '0;
      frow_q      <= '0;
      fcol_q      <= '0;
      shift_q     <= 1'b0;
      tab_q       <= '0;
      scr_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      frow_q      <= frow_d;
      fcol_q      <= fcol_d;
      shift_q     <= shift_d;
      tab_q       <= tab_d;
      scr_q       <= scr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    if (out_valid_d && !(out_valid_q && !out_ready_i)) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // cursor never goes further than one row past the screen
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= PAST_ROW) else $error("cursor row out of range");

  // a pending scroll always sits at column zero
  a_pending_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q == PAST_ROW) |-> (col_q == '0)) else $error("pending scroll off column zero");

  // backspace boundary never lies ahead of the cursor
  a_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((frow_q > row_q) || ((frow_q == row_q) && (fcol_q > col_q))))
    else $error("backspace boundary ahead of cursor");

  // end of a scroll lands at the start of the bottom row
  a_scroll_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SCROLL) && (cnt_q == END_SCROLL)) |=>
      ((row_q == LAST_ROW) && (col_q == '0) && scr_q))
    else $error("scroll did not home to bottom row");

  // one beat in flight: no accept right after an accept
  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o) else $error("input taken while busy");

endmodule
